// ===== rtl/core/sfcc_pkg.sv =====
// Shared types, constants and the CRC-8 step for the sensor frame checker.
`timescale 1ns / 1ps
package sfcc_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [30:0] ROUND_HALF  = 31'd32767;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  // Position of the next byte within the six-byte frame.
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  // A completed frame handed from the frame tracker to the scaler.
  typedef struct packed {
    logic        ok;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } frame_t;

  // One byte through the MSB-first CRC-8 register.
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(n / 65535) for n below 2^31: n = q0*65536 + lo, so the remainder
  // against 65535 is lo + q0, which stays below twice the divisor.
  function automatic logic [14:0] div_full_scale(input logic [30:0] n);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = n[30:16];
    r  = {1'b0, n[15:0]} + {2'b00, q0};
    return (r >= FULL_SCALE) ? q0 + 15'd1 : q0;
  endfunction

endpackage

// ===== rtl/core/sfcc_if.sv =====
// Valid/ready channel interfaces for the input bytes and the results.
`timescale 1ns / 1ps
interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcc_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;

  modport source (output valid, output status, output temperature_centi,
                  output humidity_centi, input ready);
  modport sink   (input valid, input status, input temperature_centi,
                  input humidity_centi, output ready);
endinterface

// ===== rtl/core/sensor_frame_crc_check_convert.sv =====
// Top level of the sensor frame CRC checker and unit converter.
`timescale 1ns / 1ps
// Usage:
// The in_ch channel carries one received sensor byte per transfer, with
// frame_start set on the first byte of a frame to realign the byte count.
// A frame is a temperature word, its CRC-8, a humidity word and its CRC-8.
// After the sixth byte one result appears on out_ch: status 0 when both
// CRCs match, with temperature in 0.01 C and humidity in 0.01 %RH; on a
// mismatch status is 1 and both values are zero.
// Throughput is one byte per cycle while in_ch.ready is high. The result
// of a frame moves from the frame register to the multiply register, then
// through the combinational divide by full scale into the output register.
// Reset (rst, synchronous) empties the pipeline and returns the byte count
// to the start of a frame. When the receiver stalls, the result holds in the
// output register and up to two more frames wait in the internal stages;
// in_ch.ready drops only when the frame register is full and cannot move.
module sensor_frame_crc_check_convert (
  input logic        clk,
  input logic        rst,
  sfcc_in_if.sink    in_ch,
  sfcc_out_if.source out_ch
);

  logic             accept;
  logic             done;
  sfcc_pkg::frame_t frame;
  logic             load_ready;

  assign in_ch.ready = load_ready;
  assign accept      = in_ch.valid && load_ready;

  sfcc_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .done        (done),
    .frame       (frame)
  );

  sfcc_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .load       (done),
    .frame      (frame),
    .load_ready (load_ready),
    .out_ch     (out_ch)
  );

endmodule

// ===== rtl/core/sfcc_frame.sv =====
// Frame tracker: byte position, running CRC and the captured raw words.
`timescale 1ns / 1ps
module sfcc_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  output logic                done,
  output sfcc_pkg::frame_t    frame
);

  sfcc_pkg::pos_t byte_position, byte_position_next;
  logic [7:0]     running_crc, running_crc_next;
  logic           first_word_crc_ok, first_word_crc_ok_next;
  logic [15:0]    first_word, first_word_next;
  logic [7:0]     second_word_high, second_word_high_next;
  logic [7:0]     second_word_low, second_word_low_next;
  sfcc_pkg::pos_t pos;
  logic [7:0]     crc_fed;

  assign pos     = frame_start ? sfcc_pkg::POS_T_HI : byte_position;
  assign crc_fed = sfcc_pkg::crc_feed(
                     (pos == sfcc_pkg::POS_T_HI || pos == sfcc_pkg::POS_H_HI) ?
                     sfcc_pkg::CRC_INIT : running_crc, rx_byte);

  always_comb begin
    byte_position_next     = byte_position;
    running_crc_next       = running_crc;
    first_word_crc_ok_next = first_word_crc_ok;
    first_word_next        = first_word;
    second_word_high_next  = second_word_high;
    second_word_low_next   = second_word_low;
    done                   = 1'b0;
    frame.ok               = first_word_crc_ok && (running_crc == rx_byte);
    frame.temp_raw         = first_word;
    frame.hum_raw          = {second_word_high, second_word_low};
    if (accept) begin
      case (pos)
        sfcc_pkg::POS_T_LO: begin
          running_crc_next   = crc_fed;
          first_word_next    = {first_word[15:8], rx_byte};
          byte_position_next = sfcc_pkg::POS_T_CRC;
        end
        sfcc_pkg::POS_T_CRC: begin
          first_word_crc_ok_next = (running_crc == rx_byte);
          running_crc_next       = sfcc_pkg::CRC_INIT;
          byte_position_next     = sfcc_pkg::POS_H_HI;
        end
        sfcc_pkg::POS_H_HI: begin
          running_crc_next      = crc_fed;
          second_word_high_next = rx_byte;
          byte_position_next    = sfcc_pkg::POS_H_LO;
        end
        sfcc_pkg::POS_H_LO: begin
          running_crc_next     = crc_fed;
          second_word_low_next = rx_byte;
          byte_position_next   = sfcc_pkg::POS_H_CRC;
        end
        sfcc_pkg::POS_H_CRC: begin
          done               = 1'b1;
          running_crc_next   = sfcc_pkg::CRC_INIT;
          byte_position_next = sfcc_pkg::POS_T_HI;
        end
        default: begin
          running_crc_next   = crc_fed;
          first_word_next    = {rx_byte, 8'h00};
          byte_position_next = sfcc_pkg::POS_T_LO;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= sfcc_pkg::POS_T_HI;
      running_crc       <= sfcc_pkg::CRC_INIT;
      first_word_crc_ok <= 1'b0;
    end else begin
      byte_position     <= byte_position_next;
      running_crc       <= running_crc_next;
      first_word_crc_ok <= first_word_crc_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    first_word       <= first_word_next;
    second_word_high <= second_word_high_next;
    second_word_low  <= second_word_low_next;
  end

endmodule

// ===== rtl/core/sfcc_scale.sv =====
// Scaling: frame register, multiply stage, combinational divide, output register.
`timescale 1ns / 1ps
module sfcc_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfcc_pkg::frame_t frame,
  output logic             load_ready,
  sfcc_out_if.source       out_ch
);

  logic             s1_valid;
  sfcc_pkg::frame_t s1;
  logic             s2_valid;
  logic             s2_ok;
  logic [30:0]      s2_temp_prod;
  logic [29:0]      s2_hum_prod;
  logic             s1_adv;
  logic             s2_adv;
  logic             out_free;
  logic [14:0]      temp_q;
  logic [14:0]      hum_q;

  assign out_free   = !out_ch.valid || out_ch.ready;
  assign s2_adv     = s2_valid && out_free;
  assign s1_adv     = s1_valid && (!s2_valid || s2_adv);
  assign load_ready = !s1_valid || s1_adv;

  assign temp_q = sfcc_pkg::div_full_scale(s2_temp_prod);
  assign hum_q  = sfcc_pkg::div_full_scale({1'b0, s2_hum_prod});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (load_ready) begin
        s1_valid <= load;
      end
      if (!s2_valid || s2_adv) begin
        s2_valid <= s1_adv;
      end
      if (out_free) begin
        out_ch.valid <= s2_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      s1 <= frame;
    end
    if (s1_adv) begin
      s2_ok        <= s1.ok;
      s2_temp_prod <= 31'(s1.temp_raw) * 31'(sfcc_pkg::TEMP_SPAN) + sfcc_pkg::ROUND_HALF;
      s2_hum_prod  <= 30'(s1.hum_raw) * 30'(sfcc_pkg::HUM_SPAN)
                      + sfcc_pkg::ROUND_HALF[29:0];
    end
    if (s2_adv) begin
      out_ch.status            <= !s2_ok;
      out_ch.temperature_centi <= s2_ok ? signed'(temp_q - sfcc_pkg::TEMP_OFFSET) : 15'sd0;
      out_ch.humidity_centi    <= s2_ok ? hum_q[13:0] : 14'd0;
    end
  end

endmodule

// ===== rtl/core/sfcc_checker.sv =====
// Port-level checks on the results, bound to the top level.
`timescale 1ns / 1ps
module sfcc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               status,
  input logic signed [14:0] temperature_centi,
  input logic        [13:0] humidity_centi
);

  // A stalled result must not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(temperature_centi) && $stable(humidity_centi))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> temperature_centi == 15'sd0 && humidity_centi == 14'd0)
    else $error("failed frame carries nonzero values");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> humidity_centi <= 14'd10000
      && temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000)
    else $error("converted value out of range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sensor_frame_crc_check_convert sfcc_checker u_sfcc_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .status            (out_ch.status),
  .temperature_centi (out_ch.temperature_centi),
  .humidity_centi    (out_ch.humidity_centi)
);
